// ----- sv/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbd_pkg - chroma box downsampler shared definitions
// Constants, per-sample control record and factor lookup functions.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int BLOCK_SIZE  = 8;
    localparam int MAX_FACTOR  = 4;
    localparam int SUM_DEPTH   = BLOCK_SIZE * MAX_FACTOR;
    localparam int POS_W       = $clog2(SUM_DEPTH);
    localparam int SUM_W       = 12;
    localparam int SAMPLE_W    = 8;
    localparam int FACTOR_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_H   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_V   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_H = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_V = 3'd3;

    typedef struct packed {
        logic [POS_W-1:0]   idx;
        logic               box_start;
        logic               box_done;
        logic               mcu_end;
        logic [1:0]         blk;
        logic [2:0]         row_in_blk;
        logic [2:0]         col_in_blk;
        logic [RECIP_W-1:0] recip;
    } t_item_ctl;

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f == 3'd0) begin
            r = 3'd1;
        end else if (f > 3'(MAX_FACTOR)) begin
            r = 3'(MAX_FACTOR);
        end else begin
            r = f;
        end
        return r;
    endfunction

    // floor(a/b), at least 1, for a and b in 1..4
    function automatic logic [FACTOR_W-1:0] step_of(input logic [FACTOR_W-1:0] a,
                                                    input logic [FACTOR_W-1:0] b);
        logic [FACTOR_W-1:0] r;
        r = 3'd1;
        case (b)
            3'd1: r = a;
            3'd2: r = (a == 3'd4) ? 3'd2 : 3'd1;
            default: r = 3'd1;
        endcase
        if (r == 3'd0) begin
            r = 3'd1;
        end
        return r;
    endfunction

    // ceil(2^RECIP_SHIFT / d), exact floor division for sums below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 21'd1048576;
            5'd2:    r = 21'd524288;
            5'd3:    r = 21'd349526;
            5'd4:    r = 21'd262144;
            5'd6:    r = 21'd174763;
            5'd8:    r = 21'd131072;
            5'd9:    r = 21'd116509;
            5'd12:   r = 21'd87382;
            5'd16:   r = 21'd65536;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/chroma_box_downsampler.sv -----
// ----------------------------------------------------------------------------
// chroma_box_downsampler - chroma box-average downsampler
// Averages luma/chroma sized boxes of one MCU region of chroma samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_sample) carries the full
//   resolution chroma samples of one MCU region in raster order. Output
//   channel (o_out_valid / i_out_stall) carries one averaged sample with its
//   block index, row, column and an MCU-last flag whenever a box completes.
//   Configuration transactions (i_cfg_valid / o_cfg_ready, always ready) set
//   the four sampling factors and restart the MCU walk; issue them only
//   while the block is idle.
//   A box result is registered on the output as its last sample leaves the
//   sum stage. Throughput: one sample per cycle unless the output stalls,
//   set by the single read-modify-write pass on the column sum memory;
//   a write-to-read bypass covers back-to-back samples of one column.
//   Reset restores all factors to 1 and the walk to row 0, column 0; the
//   sum memory needs no clearing, each box starts its sum afresh.
//   When the receiver stalls with a result held, the sum stage holds its
//   sample if it also completes a box, and the input stalls behind it.
// ----------------------------------------------------------------------------
module chroma_box_downsampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbd_pkg::FACTOR_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_average,
    output logic [1:0]                    o_block_index,
    output logic [2:0]                    o_row_in_block,
    output logic [2:0]                    o_col_in_block,
    output logic                          o_mcu_last
);
    import cbd_pkg::*;

    t_item_ctl          head_ctl;
    t_item_ctl          r_s1_ctl;
    logic [7:0]         r_s1_sample;
    logic               r_s1_valid;
    logic               r_byp;
    logic [SUM_W-1:0]   r_byp_data;
    logic [SUM_W-1:0]   rd_data;
    logic [SUM_W-1:0]   old_sum;
    logic [SUM_W-1:0]   new_sum;
    logic [PROD_W-1:0]  prod;
    logic               in_accept;
    logic               s1_go;
    logic               r_out_valid;
    logic [7:0]         r_average;
    logic [1:0]         r_block_index;
    logic [2:0]         r_row_in_block;
    logic [2:0]         r_col_in_block;
    logic               r_mcu_last;

    assign o_cfg_ready = 1'b1;

    assign s1_go      = r_s1_valid && (!r_s1_ctl.box_done || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    cbd_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (in_accept),
        .o_ctl       (head_ctl)
    );

    cbd_sum_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_ctl.idx),
        .i_wr_data (new_sum),
        .i_rd_en   (in_accept),
        .i_rd_addr (head_ctl.idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        old_sum = r_byp ? r_byp_data : rd_data;
        new_sum = r_s1_ctl.box_start ? SUM_W'(r_s1_sample)
                                     : old_sum + SUM_W'(r_s1_sample);
        prod    = PROD_W'(new_sum) * PROD_W'(r_s1_ctl.recip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl    <= head_ctl;
            r_s1_sample <= i_sample;
            r_byp       <= s1_go && (r_s1_ctl.idx == head_ctl.idx);
            r_byp_data  <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_ctl.box_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctl.box_done) begin
            r_average      <= prod[RECIP_SHIFT +: 8];
            r_block_index  <= r_s1_ctl.blk;
            r_row_in_block <= r_s1_ctl.row_in_blk;
            r_col_in_block <= r_s1_ctl.col_in_blk;
            r_mcu_last     <= r_s1_ctl.mcu_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_average      = r_average;
    assign o_block_index  = r_block_index;
    assign o_row_in_block = r_row_in_block;
    assign o_col_in_block = r_col_in_block;
    assign o_mcu_last     = r_mcu_last;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_ctl.box_done) |=> o_out_valid)
        else $error("completed box did not reach the output register");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1_ctl.box_done && o_out_valid))
        else $error("input stalled without a blocked result");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_ctl)
                                    && $stable(r_s1_sample)))
        else $error("sum stage changed while blocked");
`endif

endmodule

// ----- sv/cbd_sum_ram.sv -----
// ----------------------------------------------------------------------------
// cbd_sum_ram - column sum memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbd_sum_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [cbd_pkg::POS_W-1:0] i_wr_addr,
    input  logic [cbd_pkg::SUM_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [cbd_pkg::POS_W-1:0] i_rd_addr,
    output logic [cbd_pkg::SUM_W-1:0] o_rd_data
);
    import cbd_pkg::*;

    logic [SUM_W-1:0] r_mem [SUM_DEPTH];
    logic [SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/cbd_walk.sv -----
// ----------------------------------------------------------------------------
// cbd_walk - factor registers and MCU raster walk
// Holds the sampling factors and the position counters; produces the
// control record for the sample at the head of the input.
// ----------------------------------------------------------------------------
module cbd_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbd_pkg::FACTOR_W-1:0]  i_cfg_data,
    input  logic                          i_advance,
    output cbd_pkg::t_item_ctl            o_ctl
);
    import cbd_pkg::*;

    logic [FACTOR_W-1:0] r_lh, r_lv, r_ch, r_cv;
    logic [POS_W-1:0]    r_row, r_col, r_out_row, r_out_col;
    logic [1:0]          r_sub_row, r_sub_col;

    logic [FACTOR_W-1:0] lh, lv, sh, sv, ch_eff;
    logic                col_last, row_last, sub_col_last, sub_row_last;
    logic [4:0]          blk_full;

    always_comb begin
        lh     = clamp_factor(r_lh);
        lv     = clamp_factor(r_lv);
        sh     = step_of(lh, clamp_factor(r_ch));
        sv     = step_of(lv, clamp_factor(r_cv));
        ch_eff = step_of(lh, sh);

        col_last     = ({1'b0, r_col} + 6'd1) >= {lh, 3'b000};
        row_last     = ({1'b0, r_row} + 6'd1) >= {lv, 3'b000};
        sub_col_last = r_sub_col == 2'(sh - 3'd1);
        sub_row_last = r_sub_row == 2'(sv - 3'd1);
        blk_full     = 5'(r_out_row[POS_W-1:3]) * 5'(ch_eff) + 5'(r_out_col[POS_W-1:3]);

        o_ctl.idx        = r_out_col;
        o_ctl.box_start  = (r_sub_row == 2'd0) && (r_sub_col == 2'd0);
        o_ctl.box_done   = sub_row_last && sub_col_last;
        o_ctl.mcu_end    = row_last && col_last;
        o_ctl.blk        = blk_full[1:0];
        o_ctl.row_in_blk = r_out_row[2:0];
        o_ctl.col_in_blk = r_out_col[2:0];
        o_ctl.recip      = recip_of(5'(sh) * 5'(sv));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lh      <= 3'd1;
            r_lv      <= 3'd1;
            r_ch      <= 3'd1;
            r_cv      <= 3'd1;
            r_row     <= '0;
            r_col     <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_sub_row <= '0;
            r_sub_col <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LUMA_H:   r_lh <= i_cfg_data;
                CFG_LUMA_V:   r_lv <= i_cfg_data;
                CFG_CHROMA_H: r_ch <= i_cfg_data;
                CFG_CHROMA_V: r_cv <= i_cfg_data;
                default: ;
            endcase
            r_row     <= '0;
            r_col     <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_sub_row <= '0;
            r_sub_col <= '0;
        end else if (i_advance) begin
            if (col_last) begin
                r_col     <= '0;
                r_out_col <= '0;
                r_sub_col <= '0;
                if (row_last) begin
                    r_row     <= '0;
                    r_out_row <= '0;
                    r_sub_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if (sub_row_last) begin
                        r_sub_row <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_sub_row <= r_sub_row + 1'b1;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (sub_col_last) begin
                    r_sub_col <= '0;
                    r_out_col <= r_out_col + 1'b1;
                end else begin
                    r_sub_col <= r_sub_col + 1'b1;
                end
            end
        end
    end

endmodule
